// ----- rtl/core/rmq_pkg.sv -----
// Shared widths, constants and types for the matrix to quaternion pipeline.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MW         = 18;                  // matrix entry width
  localparam int CW         = 20;                  // signed component width
  localparam int RW         = 19;                  // radicand width
  localparam int MAGW       = 19;                  // component magnitude width
  localparam int SQW        = 2 * MAGW;            // squared magnitude width
  localparam int QSW        = 39;                  // sum of squares width
  localparam int NFW        = 16;                  // norm floor width
  localparam int FMW        = 2 * NFW + RW;        // floor product width
  localparam int NW         = 20;                  // root width
  localparam int SQRT_STEPS = NW;
  localparam int QW         = FRAC_BITS + 1;       // quotient width
  localparam int NUMW       = MAGW + FRAC_BITS + 1;
  localparam int DIV_LAT    = QW + 1;
  localparam int OUTW       = 18;
  localparam int FRONT      = 4;                   // stages ahead of the root
  localparam int TOTAL      = FRONT + SQRT_STEPS + DIV_LAT + 1;

  localparam logic [NFW-1:0] NORM_FLOOR_RESET = NFW'(1);
  localparam logic [OUTW-1:0] ONE_Q = OUTW'(1 << FRAC_BITS);

  typedef struct packed {
    logic [3:0] neg;
    logic       ident;
  } sgn_t;

  typedef struct packed {
    logic [3:0][MAGW-1:0] mag;
    sgn_t                 sg;
  } side_t;

endpackage

// ----- rtl/core/rmq_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rmq_isqrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [rmq_pkg::QSW-1:0]  x,
  output logic [rmq_pkg::NW-1:0]   root
);

  localparam int NW   = rmq_pkg::NW;
  localparam int XW   = 2 * NW;
  localparam int REMW = NW + 2;
  localparam int N    = rmq_pkg::SQRT_STEPS;

  logic [REMW-1:0] rem_q  [N];
  logic [NW-1:0]   root_q [N];
  logic [XW-1:0]   x_q    [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [REMW-1:0] src_rem;
    logic [NW-1:0]   src_root;
    logic [XW-1:0]   src_x;
    logic [REMW+1:0] remsh;
    logic [REMW+1:0] trial;
    logic            ge;

    if (j == 0) begin : g_first
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_x    = XW'(x);
    end else begin : g_next
      assign src_rem  = rem_q[j-1];
      assign src_root = root_q[j-1];
      assign src_x    = x_q[j-1];
    end

    assign remsh = {src_rem, src_x[XW-1:XW-2]};
    assign trial = (REMW+2)'({src_root, 2'b01});
    assign ge    = remsh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= ge ? REMW'(remsh - trial) : REMW'(remsh);
        root_q[j] <= {src_root[NW-2:0], ge};
        x_q[j]    <= src_x << 2;
      end
    end
  end

  assign root = root_q[N-1];

endmodule

// ----- rtl/core/rmq_div.sv -----
// Pipelined restoring divider for one rounded, normalized component.
`timescale 1ns / 1ps

module rmq_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [rmq_pkg::MAGW-1:0] mag,
  input  logic [rmq_pkg::NW-1:0]   n,
  output logic [rmq_pkg::QW-1:0]   quo
);

  localparam int NW   = rmq_pkg::NW;
  localparam int QW   = rmq_pkg::QW;
  localparam int NUMW = rmq_pkg::NUMW;

  logic [NUMW-1:0] num_p;
  logic [NW-1:0]   n_p;

  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [NW-1:0] dv_q  [QW];

  // Rounding adds half the divisor before the divide.
  always_ff @(posedge clk) begin
    if (en) begin
      num_p <= (NUMW'(mag) << rmq_pkg::FRAC_BITS) + NUMW'(n >> 1);
      n_p   <= n;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [NW-1:0] src_rem;
    logic [QW-1:0] src_low;
    logic [QW-1:0] src_quo;
    logic [NW-1:0] src_dv;
    logic [NW:0]   remsh;
    logic          ge;

    if (j == 0) begin : g_first
      // The quotient stays below 2^QW, so the upper bits start below the divisor.
      assign src_rem = NW'(num_p[NUMW-1:QW]);
      assign src_low = num_p[QW-1:0];
      assign src_quo = '0;
      assign src_dv  = n_p;
    end else begin : g_next
      assign src_rem = rem_q[j-1];
      assign src_low = low_q[j-1];
      assign src_quo = quo_q[j-1];
      assign src_dv  = dv_q[j-1];
    end

    assign remsh = {src_rem, src_low[QW-1]};
    assign ge    = remsh >= {1'b0, src_dv};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? NW'(remsh - {1'b0, src_dv}) : remsh[NW-1:0];
        low_q[j] <= src_low << 1;
        quo_q[j] <= {src_quo[QW-2:0], ge};
        dv_q[j]  <= src_dv;
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ----- rtl/core/rotation_matrix_to_quaternion_top.sv -----
// Top level: rotation matrix to unit quaternion, fully pipelined.
// From input accept to output valid the data passes four front stages,
// twenty root stages and eighteen divider stages per lane, then the output register.
// Throughput is one word per cycle while the output is not stalled; the root and divider chains are pipelined.
// A stalled output holds the whole pipeline in place.
// Synchronous reset clears all valid bits and sets norm_floor to 1.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rmq_pkg::NFW-1:0]       cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [rmq_pkg::MW-1:0] m00,
  input  logic signed [rmq_pkg::MW-1:0] m01,
  input  logic signed [rmq_pkg::MW-1:0] m02,
  input  logic signed [rmq_pkg::MW-1:0] m10,
  input  logic signed [rmq_pkg::MW-1:0] m11,
  input  logic signed [rmq_pkg::MW-1:0] m12,
  input  logic signed [rmq_pkg::MW-1:0] m20,
  input  logic signed [rmq_pkg::MW-1:0] m21,
  input  logic signed [rmq_pkg::MW-1:0] m22,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [rmq_pkg::OUTW-1:0] quat_w,
  output logic signed [rmq_pkg::OUTW-1:0] quat_x,
  output logic signed [rmq_pkg::OUTW-1:0] quat_y,
  output logic signed [rmq_pkg::OUTW-1:0] quat_z,
  output logic                          identity_used
);

  localparam int AW    = rmq_pkg::CW + 1;
  localparam int CW    = rmq_pkg::CW;
  localparam int RW    = rmq_pkg::RW;
  localparam int MAGW  = rmq_pkg::MAGW;
  localparam int SQW   = rmq_pkg::SQW;
  localparam int QSW   = rmq_pkg::QSW;
  localparam int NFW   = rmq_pkg::NFW;
  localparam int FMW   = rmq_pkg::FMW;
  localparam int NW    = rmq_pkg::NW;
  localparam int QW    = rmq_pkg::QW;
  localparam int OUTW  = rmq_pkg::OUTW;
  localparam int TOTAL = rmq_pkg::TOTAL;
  localparam int CMPW  = QSW + rmq_pkg::FRAC_BITS;

  localparam logic signed [AW-1:0] ONE_A = AW'(1 << rmq_pkg::FRAC_BITS);
  localparam logic [QW-1:0]        ONE_QW = QW'(1 << rmq_pkg::FRAC_BITS);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  logic           en;
  logic           v [TOTAL];
  logic [NFW-1:0] norm_floor;
  logic [2*NFW-1:0] nf2;

  assign en        = !v[TOTAL-1] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = v[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_floor <= rmq_pkg::NORM_FLOOR_RESET;
    end else if (cfg_valid) begin
      norm_floor <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    nf2 <= norm_floor * norm_floor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOTAL; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int i = 1; i < TOTAL; i++) v[i] <= v[i-1];
    end
  end

  // Stage 1: pick the leading component and form the scaled vector.
  logic signed [AW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [AW-1:0] trace, rr;
  logic signed [AW-1:0] c [4];
  logic [1:0]           axis;

  assign e00 = AW'(m00);
  assign e01 = AW'(m01);
  assign e02 = AW'(m02);
  assign e10 = AW'(m10);
  assign e11 = AW'(m11);
  assign e12 = AW'(m12);
  assign e20 = AW'(m20);
  assign e21 = AW'(m21);
  assign e22 = AW'(m22);

  always_comb begin
    trace = e00 + e11 + e22;
    axis  = AXIS_X;
    if (e11 > e00) axis = AXIS_Y;
    if (e22 > ((axis == AXIS_Y) ? e11 : e00)) axis = AXIS_Z;
    rr = '0;
    for (int k = 0; k < 4; k++) c[k] = '0;
    if (trace > 0) begin
      rr   = trace + ONE_A;
      c[0] = rr;
      c[1] = e12 - e21;
      c[2] = e20 - e02;
      c[3] = e01 - e10;
    end else begin
      case (axis)
        AXIS_Y:  rr = e11 - e22 - e00 + ONE_A;
        AXIS_Z:  rr = e22 - e00 - e11 + ONE_A;
        default: rr = e00 - e11 - e22 + ONE_A;
      endcase
      if (rr < 0) rr = '0;
      case (axis)
        AXIS_Y: begin
          c[0] = e20 - e02;
          c[1] = e10 + e01;
          c[2] = rr;
          c[3] = e12 + e21;
        end
        AXIS_Z: begin
          c[0] = e01 - e10;
          c[1] = e20 + e02;
          c[2] = e21 + e12;
          c[3] = rr;
        end
        default: begin
          c[0] = e12 - e21;
          c[1] = rr;
          c[2] = e01 + e10;
          c[3] = e02 + e20;
        end
      endcase
    end
  end

  logic signed [CW-1:0] s1_c [4];
  logic [RW-1:0]        s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) s1_c[k] <= CW'(c[k]);
      s1_r <= RW'(rr);
    end
  end

  // Stage 2: magnitudes and squares.
  logic [3:0]           s2_neg;
  logic [3:0][MAGW-1:0] s2_mag;
  logic [SQW-1:0]       s2_sq [4];
  logic [RW-1:0]        s2_r;
  logic [MAGW-1:0]      mag1 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag1[k] = $unsigned(MAGW'((s1_c[k] < 0) ? -s1_c[k] : s1_c[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s2_neg[k] <= s1_c[k] < 0;
        s2_mag[k] <= mag1[k];
        s2_sq[k]  <= mag1[k] * mag1[k];
      end
      s2_r <= s1_r;
    end
  end

  // Stage 3: sum of squares and the floor product.
  logic [3:0]           s3_neg;
  logic [3:0][MAGW-1:0] s3_mag;
  logic [QSW-1:0]       s3_qsum;
  logic [FMW-1:0]       s3_fm;
  logic                 s3_rzero;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_neg   <= s2_neg;
      s3_mag   <= s2_mag;
      s3_qsum  <= QSW'(s2_sq[0]) + QSW'(s2_sq[1]) + QSW'(s2_sq[2]) + QSW'(s2_sq[3]);
      s3_fm    <= nf2 * s2_r;
      s3_rzero <= s2_r == '0;
    end
  end

  // Stage 4: floor test, norm^2 * 2^F against 4 * floor^2 * R.
  rmq_pkg::side_t  s4_side;
  logic [QSW-1:0]  s4_qsum;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side.mag      <= s3_mag;
      s4_side.sg.neg   <= s3_neg;
      s4_side.sg.ident <= s3_rzero ||
                          ({s3_qsum, {rmq_pkg::FRAC_BITS{1'b0}}} < CMPW'({s3_fm, 2'b00}));
      s4_qsum          <= s3_qsum;
    end
  end

  logic [NW-1:0] root;

  rmq_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x    (s4_qsum),
    .root (root)
  );

  rmq_pkg::side_t sb1 [rmq_pkg::SQRT_STEPS];
  rmq_pkg::sgn_t  sb2 [rmq_pkg::DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sb1[0] <= s4_side;
      for (int i = 1; i < rmq_pkg::SQRT_STEPS; i++) sb1[i] <= sb1[i-1];
      sb2[0] <= sb1[rmq_pkg::SQRT_STEPS-1].sg;
      for (int i = 1; i < rmq_pkg::DIV_LAT; i++) sb2[i] <= sb2[i-1];
    end
  end

  logic [QW-1:0] quo [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    rmq_div u_div (
      .clk (clk),
      .en  (en),
      .mag (sb1[rmq_pkg::SQRT_STEPS-1].mag[k]),
      .n   (root),
      .quo (quo[k])
    );
  end

  // Output register: saturate, restore sign, substitute the identity.
  logic signed [OUTW-1:0] comp [4];
  rmq_pkg::sgn_t          sg_last;

  assign sg_last = sb2[rmq_pkg::DIV_LAT-1];

  always_comb begin
    logic [QW-1:0] qs;
    for (int k = 0; k < 4; k++) begin
      qs = (quo[k] > ONE_QW) ? ONE_QW : quo[k];
      comp[k] = sg_last.neg[k] ? -OUTW'(qs) : OUTW'(qs);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sg_last.ident) begin
        quat_w <= rmq_pkg::ONE_Q;
        quat_x <= '0;
        quat_y <= '0;
        quat_z <= '0;
      end else begin
        quat_w <= comp[0];
        quat_x <= comp[1];
        quat_y <= comp[2];
        quat_z <= comp[3];
      end
      identity_used <= sg_last.ident;
    end
  end

endmodule

// ----- rtl/core/rmq_checker.sv -----
// Port-level checks on the matrix to quaternion top level, with its bind.
`timescale 1ns / 1ps

module rmq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [rmq_pkg::NFW-1:0]       cfg_data,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [rmq_pkg::MW-1:0] m00,
  input logic signed [rmq_pkg::MW-1:0] m01,
  input logic signed [rmq_pkg::MW-1:0] m02,
  input logic signed [rmq_pkg::MW-1:0] m10,
  input logic signed [rmq_pkg::MW-1:0] m11,
  input logic signed [rmq_pkg::MW-1:0] m12,
  input logic signed [rmq_pkg::MW-1:0] m20,
  input logic signed [rmq_pkg::MW-1:0] m21,
  input logic signed [rmq_pkg::MW-1:0] m22,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [rmq_pkg::OUTW-1:0] quat_w,
  input logic signed [rmq_pkg::OUTW-1:0] quat_x,
  input logic signed [rmq_pkg::OUTW-1:0] quat_y,
  input logic signed [rmq_pkg::OUTW-1:0] quat_z,
  input logic                          identity_used
);

  localparam logic signed [rmq_pkg::OUTW-1:0] ONE_S = rmq_pkg::ONE_Q;

  // A stalled word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
      && $stable(quat_y) && $stable(quat_z) && $stable(identity_used))
    else $error("output word changed while stalled");

  // The whole pipeline stalls behind a waiting output word.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // A substituted word is exactly the identity.
  a_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && identity_used |-> quat_w == ONE_S && quat_x == '0
      && quat_y == '0 && quat_z == '0)
    else $error("identity word malformed");

  // Normalized components never exceed one in magnitude.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_w <= ONE_S && quat_w >= -ONE_S && quat_x <= ONE_S
      && quat_x >= -ONE_S && quat_y <= ONE_S && quat_y >= -ONE_S
      && quat_z <= ONE_S && quat_z >= -ONE_S)
    else $error("component out of range");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);

// ----- tb/rotation_matrix_to_quaternion_top_test.sv -----
// Self-checking testbench for the rotation matrix to quaternion block.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top_test;

  typedef logic signed [rmq_pkg::MW-1:0] ment_t;

  typedef struct {
    logic signed [rmq_pkg::OUTW-1:0] w, x, y, z;
    logic                            ident;
  } quat_t;

  typedef struct {
    ment_t m [9];
    logic  has_exp;
    quat_t exp;
  } row_t;

  localparam longint ONE = 64'sd1 << rmq_pkg::FRAC_BITS;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [rmq_pkg::NFW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  ment_t m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0, m20 = 0, m21 = 0, m22 = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [rmq_pkg::OUTW-1:0] quat_w, quat_x, quat_y, quat_z;
  logic identity_used;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .out_valid(out_valid), .out_ready(out_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .identity_used(identity_used)
  );

  quat_t pending_quats [$];
  longint unsigned floor_reg;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [rmq_pkg::OUTW-1:0] scale_to_unit(longint c,
                                                                     longint unsigned n);
    longint unsigned mag, q;
    mag = (c < 0) ? longint'(-c) : c;
    q = ((mag << rmq_pkg::FRAC_BITS) + (n >> 1)) / n;
    if (q > ONE) q = ONE;
    return (c < 0) ? rmq_pkg::OUTW'(-longint'(q)) : rmq_pkg::OUTW'(q);
  endfunction

  function automatic quat_t predict_quat(ment_t mi [9]);
    longint mm [3][3];
    longint q [4];
    longint r;
    int i, j, k;
    logic id;
    logic [127:0] lhs, rhs;
    longint unsigned qsum, n, mag;
    quat_t res;
    for (int a = 0; a < 9; a++) mm[a / 3][a % 3] = mi[a];
    if (mm[0][0] + mm[1][1] + mm[2][2] > 0) begin
      r = mm[0][0] + mm[1][1] + mm[2][2] + ONE;
      q[0] = r;
      q[1] = mm[1][2] - mm[2][1];
      q[2] = mm[2][0] - mm[0][2];
      q[3] = mm[0][1] - mm[1][0];
    end else begin
      i = 0;
      if (mm[1][1] > mm[0][0]) i = 1;
      if (mm[2][2] > mm[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      r = mm[i][i] - mm[j][j] - mm[k][k] + ONE;
      if (r < 0) r = 0;
      q[0] = mm[j][k] - mm[k][j];
      q[1 + i] = r;
      q[1 + j] = mm[i][j] + mm[j][i];
      q[1 + k] = mm[i][k] + mm[k][i];
    end
    id = (r == 0);
    qsum = 0;
    if (!id) begin
      for (int a = 0; a < 4; a++) begin
        mag = (q[a] < 0) ? longint'(-q[a]) : q[a];
        qsum += mag * mag;
      end
      lhs = 128'(qsum) << rmq_pkg::FRAC_BITS;
      rhs = 128'(4 * floor_reg * floor_reg) * 128'(r);
      if (lhs < rhs) id = 1;
    end
    if (id) begin
      res = '{w: rmq_pkg::ONE_Q, x: 0, y: 0, z: 0, ident: 1'b1};
    end else begin
      n = int_sqrt(qsum);
      res.w = scale_to_unit(q[0], n);
      res.x = scale_to_unit(q[1], n);
      res.y = scale_to_unit(q[2], n);
      res.z = scale_to_unit(q[3], n);
      res.ident = 1'b0;
    end
    return res;
  endfunction

  task automatic write_floor(logic [rmq_pkg::NFW-1:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    floor_reg = v;
  endtask

  // Sends one word; the expected result is queued at the accepting edge.
  // Ready only changes at rising edges, so it is read at the falling edge before the accepting edge.
  task automatic send_matrix(ment_t mi [9], quat_t expq, logic use_exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {mi[0], mi[1], mi[2], mi[3], mi[4], mi[5], mi[6], mi[7], mi[8]};
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    pending_quats.push_back(use_exp ? expq : predict_quat(mi));
  endtask

  task automatic wait_empty;
    in_valid <= 0;
    while (pending_quats.size() != 0) @(posedge clk);
  endtask

  task automatic drain;
    wait_empty();
    repeat (60) @(posedge clk);
  endtask

  // A random rotation-like matrix: mostly unit-scale entries, some full range, some tiny.
  function automatic void rand_matrix(output ment_t mi [9]);
    int mode;
    mode = $urandom_range(9);
    for (int a = 0; a < 9; a++) begin
      if (mode < 6) mi[a] = ment_t'($signed($urandom_range(131072)) - 65536);
      else if (mode < 8) mi[a] = ment_t'($urandom);
      else mi[a] = ment_t'($signed($urandom_range(64)) - 32);
    end
    if (mode == 9) mi[$urandom_range(2) * 4] = ment_t'($urandom_range(1) ? 65536 : -65536);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (pending_quats.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          quat_t e;
          e = pending_quats.pop_front();
          if (quat_w !== e.w) begin
            $error("quat_w expected %0d got %0d", e.w, quat_w); fail_count++;
          end
          if (quat_x !== e.x) begin
            $error("quat_x expected %0d got %0d", e.x, quat_x); fail_count++;
          end
          if (quat_y !== e.y) begin
            $error("quat_y expected %0d got %0d", e.y, quat_y); fail_count++;
          end
          if (quat_z !== e.z) begin
            $error("quat_z expected %0d got %0d", e.z, quat_z); fail_count++;
          end
          if (identity_used !== e.ident) begin
            $error("identity_used expected %0d got %0d", e.ident, identity_used);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    row_t dir [$];
    row_t rw;
    ment_t mi [9];
    quat_t idq;
    logic [rmq_pkg::NFW-1:0] floors [5];
    idq = '{w: rmq_pkg::ONE_Q, x: 0, y: 0, z: 0, ident: 1'b1};
    floor_reg = rmq_pkg::NORM_FLOOR_RESET;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed rows: identity, zero matrix, axis flips, ties, extremes.
    rw.has_exp = 0;
    rw.m = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
    rw.has_exp = 1; rw.exp = '{w: rmq_pkg::ONE_Q, x: 0, y: 0, z: 0, ident: 0};
    dir.push_back(rw);
    rw.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    rw.exp = '{w: 0, x: rmq_pkg::ONE_Q, y: 0, z: 0, ident: 0}; dir.push_back(rw);
    rw.has_exp = 0;
    rw.m = '{65536, 0, 0, 0, -65536, 0, 0, 0, -65536}; dir.push_back(rw);
    rw.m = '{-65536, 0, 0, 0, 65536, 0, 0, 0, -65536}; dir.push_back(rw);
    rw.m = '{-65536, 0, 0, 0, -65536, 0, 0, 0, 65536}; dir.push_back(rw);
    rw.m = '{0, -65536, 0, 65536, 0, 0, 0, 0, 65536}; dir.push_back(rw);
    rw.m = '{-131072, 0, 0, 0, -131072, 0, 0, 0, -131072}; dir.push_back(rw);
    rw.m = '{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071};
    dir.push_back(rw);
    rw.m = '{-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072,
             -131072}; dir.push_back(rw);
    rw.m = '{-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071,
             -131072}; dir.push_back(rw);
    rw.m = '{1, 0, 0, 0, 0, 0, 0, 0, -1}; dir.push_back(rw);
    rw.m = '{-32768, 1, 2, 3, -32768, 5, 6, 7, -32768}; dir.push_back(rw);
    rw.m = '{0, 100, -100, 200, 0, 300, -300, 400, -65536}; dir.push_back(rw);
    rw.m = '{-65536, 7, 7, 7, -65536, 7, 7, 7, 0}; dir.push_back(rw);

    foreach (dir[d]) send_matrix(dir[d].m, dir[d].exp, dir[d].has_exp);
    drain();

    floors = '{16'd0, 16'd65535, 16'd300, 16'd40000, 16'd1};
    for (int ph = 0; ph < 5; ph++) begin
      write_floor(floors[ph]);
      case (ph)
        0: begin send_idle_pct = 7; recv_idle_pct = 56; end
        2: begin send_idle_pct = 56; recv_idle_pct = 7; end
        4: begin send_idle_pct = 0; recv_idle_pct = 0; end
        default: ;
      endcase
      for (int n = 0; n < 330; n++) begin
        rand_matrix(mi);
        send_matrix(mi, idq, 1'b0);
        // Once per phase, hold off until the pipeline is empty.
        if (n == 150) wait_empty();
      end
      drain();
    end

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
